### hdl/heightmap_lod_downsampler_top_assert.svh
// Assertion macros for the heightmap LOD downsampler.
`ifndef HEIGHTMAP_LOD_DOWNSAMPLER_TOP_ASSERT_SVH
`define HEIGHTMAP_LOD_DOWNSAMPLER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define HLD_ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define HLD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/hld_pkg.sv
// Shared types and constants of the heightmap LOD downsampler.
package hld_pkg;

  localparam int unsigned LOG2_BITS   = 4;
  localparam logic [3:0]  LOG2_RESET  = 4'd10;
  localparam int unsigned COORD_BITS  = 10;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    OP_STORE,
    OP_COPY,
    OP_PAIR,
    OP_COL,
    OP_BLOCK
  } op_e;

  typedef struct packed {
    op_e  op;
    logic fin;
  } ctrl_t;

endpackage

### hdl/hld_if.sv
// Handshake channel interfaces: sample in, result out, configuration write.
interface hld_height_if #(
  parameter int unsigned HEIGHT_BITS = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [HEIGHT_BITS-1:0] height_in;

  modport source (output valid, output height_in, input ready);
  modport sink   (input valid, input height_in, output ready);
endinterface

interface hld_result_if import hld_pkg::*; #(
  parameter int unsigned HEIGHT_BITS = 24
) ();
  logic                          valid;
  logic                          ready;
  logic signed [HEIGHT_BITS-1:0] height_out;
  logic [COORD_BITS-1:0]         out_col;
  logic [COORD_BITS-1:0]         out_row;
  logic                          last;
  logic signed [HEIGHT_BITS-1:0] min_height;
  logic signed [HEIGHT_BITS-1:0] max_height;

  modport source (output valid, output height_out, output out_col, output out_row,
                  output last, output min_height, output max_height, input ready);
  modport sink   (input valid, input height_out, input out_col, input out_row,
                  input last, input min_height, input max_height, output ready);
endinterface

interface hld_cfg_if import hld_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [LOG2_BITS-1:0] source_log2;

  modport source (output valid, output source_log2, input ready);
  modport sink   (input valid, input source_log2, output ready);
endinterface

### hdl/hld_ram.sv
// Generic simple dual-port RAM with registered read.
module hld_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/hld_queue.sv
// Short FIFO between the classifying front and the arithmetic back.
module hld_queue import hld_pkg::*; #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]    mem_q [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q;
  logic [PTR_BITS-1:0] rd_ptr_q;
  logic [CNT_BITS-1:0] count_q;
  logic [CNT_BITS-1:0] count_d;

  assign ready_o = (count_q != CNT_BITS'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_d = count_q + CNT_BITS'(push_i) - CNT_BITS'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### hdl/hld_front.sv
// Front end: configuration, raster counters, sample classification, running min/max.
module hld_front import hld_pkg::*; #(
  parameter int unsigned MAX_LOG2    = 10,
  parameter int unsigned HEIGHT_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  hld_cfg_if.sink                       cfg_i,
  hld_height_if.sink                    height_i,
  input  logic                          q_ready_i,
  output logic                          push_o,
  output ctrl_t                         ctrl_o,
  output logic signed [HEIGHT_BITS-1:0] a_o,
  output logic signed [HEIGHT_BITS-1:0] b_o,
  output logic [MAX_LOG2-1:0]           x_o,
  output logic [MAX_LOG2-1:0]           y_o,
  output logic signed [HEIGHT_BITS-1:0] min_o,
  output logic signed [HEIGHT_BITS-1:0] max_o
);

  localparam int unsigned CW = MAX_LOG2 + 1;
  localparam logic signed [HEIGHT_BITS-1:0] HMAX = {1'b0, {(HEIGHT_BITS-1){1'b1}}};
  localparam logic signed [HEIGHT_BITS-1:0] HMIN = {1'b1, {(HEIGHT_BITS-1){1'b0}}};

  logic [LOG2_BITS-1:0]          log2_q;
  logic [CW-1:0]                 col_q;
  logic [CW-1:0]                 row_q;
  logic signed [HEIGHT_BITS-1:0] left_q;
  logic signed [HEIGHT_BITS-1:0] min_q;
  logic signed [HEIGHT_BITS-1:0] max_q;

  logic [LOG2_BITS-1:0]          k;
  logic [CW-1:0]                 last_idx;
  logic                          col_last;
  logic                          row_last;
  logic                          accept;
  logic                          take_left;
  logic signed [HEIGHT_BITS-1:0] h;

  always_comb begin
    priority if (log2_q < LOG2_BITS'(1)) begin
      k = LOG2_BITS'(1);
    end else if (log2_q > LOG2_BITS'(MAX_LOG2)) begin
      k = LOG2_BITS'(MAX_LOG2);
    end else begin
      k = log2_q;
    end
  end

  assign last_idx = CW'(1) << k;
  assign col_last = (col_q == last_idx);
  assign row_last = (row_q == last_idx);
  assign h        = height_i.height_in;

  // Hold the sample stream while a configuration word is offered.
  assign cfg_i.ready    = 1'b1;
  assign height_i.ready = q_ready_i && !cfg_i.valid;
  assign accept         = height_i.valid && q_ready_i && !cfg_i.valid;

  always_comb begin
    take_left  = 1'b0;
    ctrl_o.op  = OP_STORE;
    ctrl_o.fin = 1'b0;
    a_o        = h;
    b_o        = '0;
    priority if (row_last) begin
      if (col_last) begin
        ctrl_o.op  = OP_COPY;
        ctrl_o.fin = 1'b1;
      end else if (!col_q[0]) begin
        take_left = 1'b1;
      end else begin
        ctrl_o.op = OP_PAIR;
        a_o       = left_q;
        b_o       = h;
      end
    end else if (!row_q[0]) begin
      if (col_last) begin
        ctrl_o.op = OP_STORE;
      end else if (!col_q[0]) begin
        take_left = 1'b1;
      end else begin
        ctrl_o.op = OP_STORE;
        a_o       = left_q;
        b_o       = h;
      end
    end else begin
      if (col_last) begin
        ctrl_o.op = OP_COL;
      end else if (!col_q[0]) begin
        take_left = 1'b1;
      end else begin
        ctrl_o.op = OP_BLOCK;
        a_o       = left_q;
        b_o       = h;
      end
    end
  end

  assign push_o = accept && !take_left;
  assign x_o    = col_q[CW-1:1];
  assign y_o    = row_q[CW-1:1];
  assign min_o  = (h < min_q) ? h : min_q;
  assign max_o  = (h > max_q) ? h : max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log2_q <= LOG2_RESET;
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
      min_q  <= HMAX;
      max_q  <= HMIN;
    end else if (cfg_i.valid) begin
      log2_q <= cfg_i.source_log2;
      col_q  <= '0;
      row_q  <= '0;
      min_q  <= HMAX;
      max_q  <= HMIN;
    end else if (accept) begin
      if (take_left) begin
        left_q <= h;
      end
      if (col_last) begin
        col_q <= '0;
        if (row_last) begin
          row_q <= '0;
          min_q <= HMAX;
          max_q <= HMIN;
        end else begin
          row_q <= row_q + 1'b1;
          min_q <= min_o;
          max_q <= max_o;
        end
      end else begin
        col_q <= col_q + 1'b1;
        min_q <= min_o;
        max_q <= max_o;
      end
    end
  end

endmodule

### hdl/hld_back.sv
// Back end: line store access, averaging, and the output register.
module hld_back import hld_pkg::*; #(
  parameter int unsigned MAX_LOG2    = 10,
  parameter int unsigned HEIGHT_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  output logic                          q_pop_o,
  input  ctrl_t                         ctrl_i,
  input  logic signed [HEIGHT_BITS-1:0] a_i,
  input  logic signed [HEIGHT_BITS-1:0] b_i,
  input  logic [MAX_LOG2-1:0]           x_i,
  input  logic [MAX_LOG2-1:0]           y_i,
  input  logic signed [HEIGHT_BITS-1:0] min_i,
  input  logic signed [HEIGHT_BITS-1:0] max_i,
  hld_result_if.source                  result_o
);

  localparam int unsigned SW    = HEIGHT_BITS + 1;
  localparam int unsigned SUMW  = HEIGHT_BITS + 3;
  localparam int unsigned DEPTH = (1 << (MAX_LOG2 - 1)) + 1;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic                          s2_v_q;
  ctrl_t                         s2_ctrl_q;
  logic signed [HEIGHT_BITS-1:0] s2_a_q;
  logic signed [HEIGHT_BITS-1:0] s2_b_q;
  logic [MAX_LOG2-1:0]           s2_x_q;
  logic [MAX_LOG2-1:0]           s2_y_q;
  logic signed [HEIGHT_BITS-1:0] s2_min_q;
  logic signed [HEIGHT_BITS-1:0] s2_max_q;

  logic                          out_v_q;
  logic signed [HEIGHT_BITS-1:0] out_h_q;
  logic [COORD_BITS-1:0]         out_col_q;
  logic [COORD_BITS-1:0]         out_row_q;
  logic                          out_last_q;
  logic signed [HEIGHT_BITS-1:0] out_min_q;
  logic signed [HEIGHT_BITS-1:0] out_max_q;

  logic                          s2_adv;
  logic                          s2_ready;
  logic                          st_we;
  logic                          st_re;
  logic signed [SW-1:0]          st_wdata;
  logic [SW-1:0]                 st_rdata;
  logic signed [SW-1:0]          st_word;
  logic                          s2_use_st;
  logic signed [SUMW-1:0]        st_term;
  logic signed [SUMW-1:0]        sum;
  logic signed [SUMW-1:0]        avg;

  assign s2_adv   = s2_v_q && (!out_v_q || result_o.ready);
  assign s2_ready = !s2_v_q || s2_adv;
  assign q_pop_o  = q_valid_i && s2_ready;

  assign st_we    = q_pop_o && (ctrl_i.op == OP_STORE);
  assign st_re    = q_pop_o && ((ctrl_i.op == OP_COL) || (ctrl_i.op == OP_BLOCK));
  assign st_wdata = SW'(a_i) + SW'(b_i);

  hld_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (AW'(x_i)),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (AW'(x_i)),
    .rdata_o (st_rdata)
  );

  assign st_word   = st_rdata;
  assign s2_use_st = (s2_ctrl_q.op == OP_COL) || (s2_ctrl_q.op == OP_BLOCK);
  assign st_term   = s2_use_st ? SUMW'(st_word) : '0;
  assign sum       = SUMW'(s2_a_q) + SUMW'(s2_b_q) + st_term;

  always_comb begin
    unique case (s2_ctrl_q.op)
      OP_PAIR, OP_COL: avg = sum >>> 1;
      OP_BLOCK:        avg = sum >>> 2;
      default:         avg = sum;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        s2_v_q <= (ctrl_i.op != OP_STORE);
      end else if (s2_adv) begin
        s2_v_q <= 1'b0;
      end
      if (s2_adv) begin
        out_v_q <= 1'b1;
      end else if (result_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s2_ctrl_q <= ctrl_i;
      s2_a_q    <= a_i;
      s2_b_q    <= b_i;
      s2_x_q    <= x_i;
      s2_y_q    <= y_i;
      s2_min_q  <= min_i;
      s2_max_q  <= max_i;
    end
    if (s2_adv) begin
      out_h_q    <= avg[HEIGHT_BITS-1:0];
      out_col_q  <= COORD_BITS'(s2_x_q);
      out_row_q  <= COORD_BITS'(s2_y_q);
      out_last_q <= s2_ctrl_q.fin;
      out_min_q  <= s2_ctrl_q.fin ? s2_min_q : '0;
      out_max_q  <= s2_ctrl_q.fin ? s2_max_q : '0;
    end
  end

  assign result_o.valid      = out_v_q;
  assign result_o.height_out = out_h_q;
  assign result_o.out_col    = out_col_q;
  assign result_o.out_row    = out_row_q;
  assign result_o.last       = out_last_q;
  assign result_o.min_height = out_min_q;
  assign result_o.max_height = out_max_q;

endmodule

### hdl/heightmap_lod_downsampler_top.sv
// Top level of the heightmap LOD downsampler: front, queue, back.
//
//   channel    dir  word                                         handshake
//   cfg_i      in   source_log2                                  valid/ready
//   height_i   in   height_in                                    valid/ready
//   result_o   out  height_out, out_col, out_row, last, min/max  valid/ready
//
// One sample per cycle sustained while result_o is ready and cfg_i is idle; a
// result passes front push, queue and store read, then the output register.
// The line store is one write and one read port, used at most once per sample.
// Reset needs no clearing pass: the line store is always written before read.
// A stall on result_o fills the four-entry queue, then drops height_i.ready.
`include "heightmap_lod_downsampler_top_assert.svh"

module heightmap_lod_downsampler_top import hld_pkg::*; #(
  parameter int unsigned MAX_LOG2    = 10,
  parameter int unsigned HEIGHT_BITS = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  hld_cfg_if.sink      cfg_i,
  hld_height_if.sink   height_i,
  hld_result_if.source result_o
);

  localparam int unsigned QW = $bits(ctrl_t) + 4 * HEIGHT_BITS + 2 * MAX_LOG2;

  logic                          q_push;
  logic                          q_ready;
  logic                          q_valid;
  logic                          q_pop;
  logic [QW-1:0]                 q_wdata;
  logic [QW-1:0]                 q_rdata;

  ctrl_t                         f_ctrl;
  logic signed [HEIGHT_BITS-1:0] f_a;
  logic signed [HEIGHT_BITS-1:0] f_b;
  logic [MAX_LOG2-1:0]           f_x;
  logic [MAX_LOG2-1:0]           f_y;
  logic signed [HEIGHT_BITS-1:0] f_min;
  logic signed [HEIGHT_BITS-1:0] f_max;

  ctrl_t                         b_ctrl;
  logic signed [HEIGHT_BITS-1:0] b_a;
  logic signed [HEIGHT_BITS-1:0] b_b;
  logic [MAX_LOG2-1:0]           b_x;
  logic [MAX_LOG2-1:0]           b_y;
  logic signed [HEIGHT_BITS-1:0] b_min;
  logic signed [HEIGHT_BITS-1:0] b_max;

  hld_front #(
    .MAX_LOG2    (MAX_LOG2),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_i),
    .height_i  (height_i),
    .q_ready_i (q_ready),
    .push_o    (q_push),
    .ctrl_o    (f_ctrl),
    .a_o       (f_a),
    .b_o       (f_b),
    .x_o       (f_x),
    .y_o       (f_y),
    .min_o     (f_min),
    .max_o     (f_max)
  );

  assign q_wdata = {f_ctrl, f_a, f_b, f_x, f_y, f_min, f_max};

  hld_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_rdata)
  );

  assign {b_ctrl, b_a, b_b, b_x, b_y, b_min, b_max} = q_rdata;

  hld_back #(
    .MAX_LOG2    (MAX_LOG2),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_pop_o   (q_pop),
    .ctrl_i    (b_ctrl),
    .a_i       (b_a),
    .b_i       (b_b),
    .x_i       (b_x),
    .y_i       (b_y),
    .min_i     (b_min),
    .max_i     (b_max),
    .result_o  (result_o)
  );

  `HLD_ASSERT_IMPLIES(a_corner_on_diag, result_o.valid && result_o.last, result_o.out_col == result_o.out_row, "final word not on the diagonal corner")
  `HLD_ASSERT_IMPLIES(a_minmax_only_last, result_o.valid && !result_o.last, (result_o.min_height == '0) && (result_o.max_height == '0), "min/max set on a non-final word")
  `HLD_ASSERT_IMPLIES(a_pop_needs_entry, q_pop, q_valid, "queue popped while empty")
  `HLD_ASSERT_NEXT(a_queue_holds, q_valid && !q_pop, q_valid, "queue entry lost without a pop")

endmodule
